>>> sv/kccp_pkg.sv
// ----------------------------------------------------------------------------
// Keypad colour command parser package
// Shared codes, widths, the result record, the status normaliser and the decimal field decoder.
// ----------------------------------------------------------------------------
package kccp_pkg;

  localparam int unsigned SeqLen   = 11;
  localparam int unsigned PosW     = $clog2(SeqLen);
  localparam int unsigned KeyW     = 4;
  localparam int unsigned PrevKeyW = KeyW + 1;
  localparam int unsigned LevelW   = 8;
  localparam int unsigned LedW     = 3;

  localparam logic [KeyW-1:0]     KeyStart = 4'hA;
  localparam logic [KeyW-1:0]     KeyLedA  = 4'h5;
  localparam logic [KeyW-1:0]     KeyLedB  = 4'h6;
  localparam logic [KeyW-1:0]     DigitMax = 4'h9;
  localparam logic [PrevKeyW-1:0] KeyNone  = 5'd16;
  localparam logic [LedW-1:0]     LedA     = 3'd5;
  localparam logic [LedW-1:0]     LedB     = 3'd6;
  localparam logic [LedW-1:0]     LedOff   = 3'd0;

  typedef logic [KeyW-1:0] key_t;

  typedef enum logic [1:0] {
    StNone   = 2'd0,
    StSingle = 2'd1,
    StMulti  = 2'd2
  } key_status_e;

  typedef enum logic [1:0] {
    EvCommand    = 2'd0,
    EvMultiError = 2'd1,
    EvRejected   = 2'd2
  } event_kind_e;

  typedef struct packed {
    event_kind_e       kind;
    logic [LedW-1:0]   led;
    logic [LevelW-1:0] red;
    logic [LevelW-1:0] green;
    logic [LevelW-1:0] blue;
  } result_t;

  // The unused status code counts as no key.
  function automatic key_status_e normalise_status(logic [1:0] raw);
    key_status_e st;
    unique case (raw)
      StSingle: st = StSingle;
      StMulti:  st = StMulti;
      default:  st = StNone;
    endcase
    return st;
  endfunction

  // Three-key decimal field: digits accumulate until the first key above 9,
  // and the value is kept modulo 256.
  function automatic logic [LevelW-1:0] field_value(key_t k0, key_t k1, key_t k2);
    logic [9:0] acc;
    if (k0 > DigitMax) begin
      acc = '0;
    end else if (k1 > DigitMax) begin
      acc = 10'(k0);
    end else if (k2 > DigitMax) begin
      acc = 10'(k0) * 10'd10 + 10'(k1);
    end else begin
      acc = 10'(k0) * 10'd100 + 10'(k1) * 10'd10 + 10'(k2);
    end
    return acc[LevelW-1:0];
  endfunction

endpackage

>>> sv/kccp_parse.sv
// ----------------------------------------------------------------------------
// Keypad colour command parser: sequence decoder
// Turns a complete eleven-key sequence into a command or a rejection.
// ----------------------------------------------------------------------------
module kccp_parse (
  input  kccp_pkg::key_t    keys_i [kccp_pkg::SeqLen],
  output kccp_pkg::result_t result_o
);
  import kccp_pkg::*;

  logic [LedW-1:0] led;

  always_comb begin
    led = LedOff;
    if (keys_i[0] == KeyStart) begin
      if (keys_i[1] == KeyLedA) begin
        led = LedA;
      end else if (keys_i[1] == KeyLedB) begin
        led = LedB;
      end
    end
  end

  always_comb begin
    result_o = '0;
    if (led != LedOff) begin
      result_o.kind  = EvCommand;
      result_o.led   = led;
      result_o.red   = field_value(keys_i[2], keys_i[3], keys_i[4]);
      result_o.green = field_value(keys_i[5], keys_i[6], keys_i[7]);
      result_o.blue  = field_value(keys_i[8], keys_i[9], keys_i[10]);
    end else begin
      result_o.kind  = EvRejected;
    end
  end

endmodule

>>> sv/kccp_tracker.sv
// ----------------------------------------------------------------------------
// Keypad colour command parser: key tracker
// Holds the previous sample, the sequence position and the key buffer, and
// decides whether the presented sample yields a result.
// ----------------------------------------------------------------------------
module kccp_tracker (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  advance_i,
  input  kccp_pkg::key_status_e status_i,
  input  kccp_pkg::key_t        key_i,
  output logic                  produce_o,
  output kccp_pkg::result_t     result_o
);
  import kccp_pkg::*;

  key_status_e         prev_status_q, prev_status_d;
  logic [PrevKeyW-1:0] prev_key_q, prev_key_d;
  logic [PosW-1:0]     pos_q, pos_d;
  key_t                buf_q [SeqLen];
  key_t                keys_eff [SeqLen];

  logic            key_new;
  logic            multi_onset;
  logic            complete;
  logic [PosW-1:0] wr_pos;
  result_t         parse_res;

  assign key_new = (status_i == StSingle) &&
                   ((prev_status_q != StSingle) || ({1'b0, key_i} != prev_key_q));
  assign wr_pos  = (key_i == KeyStart) ? '0 : pos_q;
  assign complete    = key_new && (wr_pos == PosW'(SeqLen - 1));
  assign multi_onset = (status_i == StMulti) && (prev_status_q != StMulti);
  assign produce_o   = complete || (!key_new && multi_onset);

  // The key being taken joins the stored ones for the parse.
  always_comb begin
    for (int i = 0; i < SeqLen; i++) begin
      keys_eff[i] = (wr_pos == PosW'(i)) ? key_i : buf_q[i];
    end
  end

  kccp_parse u_parse (
    .keys_i   (keys_eff),
    .result_o (parse_res)
  );

  always_comb begin
    result_o = '0;
    if (complete) begin
      result_o = parse_res;
    end else begin
      result_o.kind = EvMultiError;
    end
  end

  always_comb begin
    prev_status_d = prev_status_q;
    prev_key_d    = prev_key_q;
    pos_d         = pos_q;
    if (advance_i) begin
      prev_status_d = status_i;
      if (key_new) begin
        if (complete) begin
          prev_status_d = StNone;
          prev_key_d    = KeyNone;
          pos_d         = '0;
        end else begin
          prev_key_d = {1'b0, key_i};
          pos_d      = wr_pos + PosW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_status_q <= StNone;
      prev_key_q    <= KeyNone;
      pos_q         <= '0;
    end else begin
      prev_status_q <= prev_status_d;
      prev_key_q    <= prev_key_d;
      pos_q         <= pos_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_i && key_new) begin
      buf_q[wr_pos] <= key_i;
    end
  end

  // The position never passes the last index, and a completed sequence returns it to zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= PosW'(SeqLen - 1))
    else $error("sequence position out of range");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance_i && complete) |=> (pos_q == '0) && (prev_key_q == KeyNone))
    else $error("state not restored after a complete sequence");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    prev_key_q != KeyNone |-> prev_key_q[PrevKeyW-1] == 1'b0)
    else $error("previous key holds an illegal marker");

endmodule

>>> sv/keypad_color_command_parser_unit.sv
// ----------------------------------------------------------------------------
// Keypad colour command parser
// Collects eleven-key colour commands from keypad samples and reports parsed
// commands, multi-key errors and rejected sequences.
// ----------------------------------------------------------------------------
// Path: a sample passes the input register, then its result the result register;
// a sample that yields a result waits in the input register while the result register is full.
// Throughput: one sample per cycle; the input stalls only while a result
// waits in the result register and the next sample also yields one.
// Reset: asynchronous, active low; clears the previous sample, the sequence
// position and both valid flags. The key buffer needs no reset.
module keypad_color_command_parser_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,  // key_status[1:0], key_value[5:2]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata   // event_kind[1:0], led_index[4:2],
                                     // red_level[12:5], green_level[20:13],
                                     // blue_level[28:21]
);
  import kccp_pkg::*;

  logic        in_valid_q, in_valid_d;
  key_status_e in_status_q;
  key_t        in_key_q;
  logic        out_valid_q, out_valid_d;
  result_t     out_res_q;

  logic    produce;
  result_t result;
  logic    out_free;
  logic    advance;
  logic    in_take;

  kccp_tracker u_tracker (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (advance),
    .status_i  (in_status_q),
    .key_i     (in_key_q),
    .produce_o (produce),
    .result_o  (result)
  );

  assign out_free      = !out_valid_q || m_axis_tready;
  assign advance       = in_valid_q && (!produce || out_free);
  assign s_axis_tready = !in_valid_q || advance;
  assign in_take       = s_axis_tvalid && s_axis_tready;

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_take) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (advance && produce) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_status_q <= normalise_status(s_axis_tdata[1:0]);
      in_key_q    <= s_axis_tdata[5:2];
    end
    if (advance && produce) begin
      out_res_q <= result;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {3'b000, out_res_q.blue, out_res_q.green, out_res_q.red,
                          out_res_q.led, out_res_q.kind};

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_res_q.kind == EvCommand) |->
      (out_res_q.led == LedA || out_res_q.led == LedB))
    else $error("command transfer with a bad LED index");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_res_q.kind != EvCommand) |->
      (out_res_q.led == LedOff && out_res_q.red == '0 &&
       out_res_q.green == '0 && out_res_q.blue == '0))
    else $error("error transfer carries non-zero fields");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && produce && !out_free) |-> !s_axis_tready)
    else $error("input taken while its result cannot be stored");

endmodule

>>> test/keypad_color_command_parser_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Keypad colour command parser testbench
// Drives keypad samples into the parser and checks every result transfer against
// a behavioural model of the key sequence, with directed sequences, back-pressure
// and random command traffic with idle bursts on both stream sides.
// ----------------------------------------------------------------------------
module keypad_color_command_parser_unit_tb;
  import kccp_pkg::*;

  localparam logic [1:0] StUnused   = 2'd3;
  localparam int unsigned StallLimit = 3000;
  localparam int unsigned DrainWait  = 10;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;   // key_status[1:0], key_value[5:2]
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [31:0] m_axis_tdata;   // event_kind[1:0], led_index[4:2], red_level[12:5],
                               // green_level[20:13], blue_level[28:21]

  // Model of the sequence collector.
  key_status_e         last_status;
  logic [PrevKeyW-1:0] last_key;
  logic [3:0]          key_count;
  key_t                held_keys [SeqLen];

  result_t     expected_events [$];
  int unsigned error_count;
  int unsigned effective_samples;
  int unsigned stall_cycles;
  int unsigned sink_hold;
  bit          src_idle_en;
  bit          sink_idle_en;

  keypad_color_command_parser_unit i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  function automatic logic [LevelW-1:0] decimal_level(int unsigned first);
    int unsigned acc;
    bit          stopped;
    acc = 0;
    stopped = 1'b0;
    for (int i = 0; i < 3; i++) begin
      if (!stopped) begin
        if (held_keys[first + i] > 4'd9) begin
          stopped = 1'b1;
        end else begin
          acc = acc * 10 + held_keys[first + i];
        end
      end
    end
    return acc[LevelW-1:0];
  endfunction

  task automatic predict_sample(input logic [1:0] raw, input key_t k);
    key_status_e     st;
    result_t         r;
    logic [LedW-1:0] led;
    st = (raw == StSingle) ? StSingle : (raw == StMulti) ? StMulti : StNone;
    if (st == StSingle && (st != last_status || {1'b0, k} != last_key)) begin
      effective_samples++;
      last_key = {1'b0, k};
      if (k == KeyStart) key_count = '0;
      if (key_count < SeqLen) begin
        held_keys[key_count] = k;
        key_count++;
      end
      if (key_count >= SeqLen) begin
        last_status = StNone;
        last_key = KeyNone;
        key_count = '0;
        led = LedOff;
        if (held_keys[0] == KeyStart) begin
          if (held_keys[1] == KeyLedA) led = LedA;
          else if (held_keys[1] == KeyLedB) led = LedB;
        end
        if (led != LedOff) begin
          r.kind  = EvCommand;
          r.led   = led;
          r.red   = decimal_level(2);
          r.green = decimal_level(5);
          r.blue  = decimal_level(8);
        end else begin
          r = '0;
          r.kind = EvRejected;
        end
        expected_events.push_back(r);
      end else begin
        last_status = st;
      end
    end else if (st == StMulti && last_status != StMulti) begin
      effective_samples++;
      last_status = st;
      r = '0;
      r.kind = EvMultiError;
      expected_events.push_back(r);
    end else begin
      last_status = st;
    end
  endtask

  // Called at a falling edge; returns at the falling edge after the transfer,
  // leaving tvalid high for the next sample.
  task automatic send_sample(input logic [1:0] raw, input key_t k);
    int unsigned gap;
    if (src_idle_en && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 19);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {2'b00, k, raw};
    do @(posedge clk_i); while (!s_axis_tready);
    predict_sample(raw, k);
    @(negedge clk_i);
  endtask

  // A repeated key only registers after the keypad has been released.
  task automatic press_key(input key_t k);
    if (last_status == StSingle && last_key == {1'b0, k})
      send_sample($urandom_range(0, 1) ? StNone : StUnused, 4'($urandom_range(0, 15)));
    send_sample(StSingle, k);
  endtask

  task automatic press_sequence(input key_t keys [SeqLen]);
    for (int i = 0; i < SeqLen; i++) press_key(keys[i]);
  endtask

  task automatic send_noise();
    send_sample(2'($urandom_range(0, 3)), 4'($urandom_range(0, 15)));
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    @(negedge clk_i);
    while (expected_events.size() != 0) @(negedge clk_i);
  endtask

  task automatic test_status_codes();
    send_sample(StNone, 4'h0);
    send_sample(StUnused, 4'hF);
    send_sample(StMulti, 4'h3);
    send_sample(StMulti, 4'h3);
    send_sample(StMulti, 4'h7);
    send_sample(StUnused, 4'h0);
    send_sample(StMulti, 4'h0);
    send_sample(StNone, 4'hA);
  endtask

  task automatic test_commands();
    // Largest three-digit field wraps, a field stopped on its second key.
    press_sequence('{KeyStart, KeyLedA, 4'h9, 4'h9, 4'h9, 4'h2, 4'h5, 4'h5,
                     4'h0, 4'hF, 4'h0});
    // Key A part way through starts the sequence again.
    press_key(KeyStart);
    press_key(KeyLedB);
    press_key(4'h1);
    press_sequence('{KeyStart, KeyLedB, 4'h0, 4'h1, 4'h2, 4'h3, 4'hB, 4'h4,
                     4'h7, 4'h8, 4'h9});
  endtask

  task automatic test_rejects();
    press_sequence('{4'h1, 4'h2, 4'h3, 4'h4, 4'h5, 4'h6, 4'h7, 4'h8, 4'h9,
                     4'h0, 4'hB});
    press_sequence('{KeyStart, 4'h7, 4'h1, 4'h2, 4'h3, 4'h4, 4'h5, 4'h6, 4'h7,
                     4'h8, 4'h9});
    // Fields that open on a stop key read as zero; a multi-key press in the
    // middle of a sequence leaves the position alone.
    press_key(KeyStart);
    press_key(KeyLedB);
    send_sample(StMulti, 4'h2);
    press_sequence('{KeyStart, KeyLedB, 4'hB, 4'h1, 4'h2, 4'hC, 4'hD, 4'hE,
                     4'h3, 4'h4, 4'hF});
  endtask

  task automatic test_backpressure();
    sink_hold = 150;
    repeat (40) begin
      send_sample(StMulti, 4'($urandom_range(0, 15)));
      send_sample(StNone, 4'($urandom_range(0, 15)));
    end
    wait_drained();
  endtask

  task automatic send_random_sequence();
    key_t keys [SeqLen];
    int unsigned pick;
    keys[0] = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(0, 15)) : KeyStart;
    if ($urandom_range(0, 9) == 0) keys[1] = 4'($urandom_range(0, 15));
    else keys[1] = $urandom_range(0, 1) ? KeyLedA : KeyLedB;
    for (int i = 2; i < SeqLen; i++) begin
      pick = $urandom_range(0, 19);
      if (pick < 15) keys[i] = 4'($urandom_range(0, 9));
      else if (pick < 19) keys[i] = 4'($urandom_range(11, 15));
      else keys[i] = 4'($urandom_range(0, 15));
    end
    for (int i = 0; i < SeqLen; i++) begin
      if ($urandom_range(0, 14) == 0) send_noise();
      if ($urandom_range(0, 2) == 0)
        send_sample($urandom_range(0, 1) ? StNone : StUnused, 4'($urandom_range(0, 15)));
      press_key(keys[i]);
      // Holding the key gives further samples that must be ignored.
      if ($urandom_range(0, 7) == 0) send_sample(StSingle, keys[i]);
    end
  endtask

  task automatic test_drain_pause();
    repeat (3) send_random_sequence();
    wait_drained();
    repeat (2) send_random_sequence();
  endtask

  task automatic test_random(input int unsigned count, input bit idle);
    int unsigned goal;
    src_idle_en  = idle;
    sink_idle_en = idle;
    goal = effective_samples + count;
    while (effective_samples < goal) begin
      if ($urandom_range(0, 9) < 7) send_random_sequence();
      else repeat ($urandom_range(1, 6)) send_noise();
    end
  endtask

  initial begin : receiver
    int unsigned burst;
    burst = 0;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (sink_hold != 0) begin
        m_axis_tready <= 1'b0;
        sink_hold--;
      end else if (burst != 0) begin
        m_axis_tready <= 1'b0;
        burst--;
      end else if (sink_idle_en && $urandom_range(0, 11) == 0) begin
        m_axis_tready <= 1'b0;
        burst = $urandom_range(1, 19) - 1;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin : result_check
    result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_events.size() == 0) begin
        $error("result transfer with no result expected: tdata %h", m_axis_tdata);
        error_count++;
      end else begin
        want = expected_events.pop_front();
        if (m_axis_tdata[1:0] != want.kind) begin
          $error("event_kind expected %0d actual %0d", want.kind, m_axis_tdata[1:0]);
          error_count++;
        end
        if (m_axis_tdata[4:2] != want.led) begin
          $error("led_index expected %0d actual %0d", want.led, m_axis_tdata[4:2]);
          error_count++;
        end
        if (m_axis_tdata[12:5] != want.red) begin
          $error("red_level expected %0d actual %0d", want.red, m_axis_tdata[12:5]);
          error_count++;
        end
        if (m_axis_tdata[20:13] != want.green) begin
          $error("green_level expected %0d actual %0d", want.green, m_axis_tdata[20:13]);
          error_count++;
        end
        if (m_axis_tdata[28:21] != want.blue) begin
          $error("blue_level expected %0d actual %0d", want.blue, m_axis_tdata[28:21]);
          error_count++;
        end
      end
    end
  end

  // Ends the run once no transfer has happened on either side for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= StallLimit) begin
        $display("keypad_color_command_parser_unit_tb: done, errors");
        $finish;
      end
    end
  end

  initial begin
    rst_ni            = 1'b0;
    s_axis_tvalid     = 1'b0;
    s_axis_tdata      = '0;
    error_count       = 0;
    effective_samples = 0;
    stall_cycles      = 0;
    sink_hold         = 0;
    src_idle_en       = 1'b0;
    sink_idle_en      = 1'b0;
    last_status       = StNone;
    last_key          = KeyNone;
    key_count         = '0;
    for (int i = 0; i < SeqLen; i++) held_keys[i] = '0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_status_codes();
    test_commands();
    test_rejects();
    test_backpressure();
    test_drain_pause();
    test_random(500, 1'b1);
    test_random(140, 1'b0);

    s_axis_tvalid <= 1'b0;
    while (expected_events.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
    if (error_count == 0) begin
      $display("keypad_color_command_parser_unit_tb: done, clean");
    end else begin
      $display("keypad_color_command_parser_unit_tb: done, errors");
    end
    $finish;
  end

endmodule
